// ===== hdl/chebyshev_coefficient_generator_defines.svh =====
// Assertion macros used by the Chebyshev coefficient generator checker.
`ifndef CHEBYSHEV_COEFFICIENT_GENERATOR_DEFINES_SVH
`define CHEBYSHEV_COEFFICIENT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHEB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chebcg: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHEB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chebcg: assertion failed");

`endif

// ===== hdl/chebcg_pkg.sv =====
// Types and constants shared by the Chebyshev coefficient generator modules.
package chebcg_pkg;

  // Fixed field widths.
  localparam int DEG_W  = 6;
  localparam int COEF_W = 61;

  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1);

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT_LO,
    ST_INIT_HI,
    ST_COMP,
    ST_DRAIN,
    ST_EMIT_RD,
    ST_EMIT_LD
  } chebcg_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic init_lo;
    logic init_hi;
    logic comp_step;
    logic row_next;
    logic emit_rd;
    logic emit_ld;
  } chebcg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_le_one;
    logic row_done;
    logic rows_done;
    logic emit_last;
    logic out_free;
  } chebcg_sts_t;

endpackage

// ===== hdl/chebcg_ctrl.sv =====
// Sequencing state machine of the Chebyshev coefficient generator.
module chebcg_ctrl
  import chebcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output chebcg_cmd_t cmd,
  input  chebcg_sts_t sts
);

  chebcg_state_t state_r;
  chebcg_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_INIT_LO;
      end
      ST_INIT_LO: begin
        state_nxt = ST_INIT_HI;
      end
      ST_INIT_HI: begin
        state_nxt = sts.n_le_one ? ST_EMIT_RD : ST_COMP;
      end
      ST_COMP: begin
        if (sts.row_done) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = sts.rows_done ? ST_EMIT_RD : ST_COMP;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts.out_free) state_nxt = sts.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Commands decoded from the current state; load also needs in_valid and emit_ld needs out_free.
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == ST_IDLE) && in_valid;
    cmd.init_lo   = (state_r == ST_INIT_LO);
    cmd.init_hi   = (state_r == ST_INIT_HI);
    cmd.comp_step = (state_r == ST_COMP);
    cmd.row_next  = (state_r == ST_DRAIN);
    cmd.emit_rd   = (state_r == ST_EMIT_RD);
    cmd.emit_ld   = (state_r == ST_EMIT_LD) && sts.out_free;
    in_ready      = (state_r == ST_IDLE);
  end

endmodule

// ===== hdl/chebcg_datapath.sv =====
// Row memories, recurrence arithmetic and output register of the generator.
module chebcg_datapath
  import chebcg_pkg::*;
#(
  parameter int MAX_DEGREE = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [DEG_W-1:0]         in_degree,
  input  chebcg_cmd_t              cmd,
  output chebcg_sts_t              sts,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [DEG_W-1:0]         out_power,
  output logic                     out_last
);

  localparam int ROW_LEN = MAX_DEGREE + 1;
  localparam int AW      = $clog2(ROW_LEN);
  localparam logic [DEG_W-1:0] MAX_DEG = DEG_W'(MAX_DEGREE);

  // The two row memories; bank_r says which one holds the newer row.
  logic [COEF_W-1:0] mem_a [ROW_LEN];
  logic [COEF_W-1:0] mem_b [ROW_LEN];

  logic [DEG_W-1:0]  n_r;
  logic [DEG_W-1:0]  i_r;
  logic [AW-1:0]     j_r;
  logic [AW-1:0]     k_r;
  logic              bank_r;
  logic [COEF_W-1:0] rd_a_r;
  logic [COEF_W-1:0] rd_b_r;
  logic              p_vld_r;
  logic [AW-1:0]     p_j_r;
  logic              p_zn_r;
  logic              p_zo_r;
  logic              out_valid_r;
  logic [COEF_W-1:0] out_coef_r;
  logic [DEG_W-1:0]  out_power_r;
  logic              out_last_r;

  logic [DEG_W-1:0]  n_sat;
  logic [AW-1:0]     j_prev;
  logic [AW-1:0]     newer_addr;
  logic [AW-1:0]     older_addr;
  logic [AW-1:0]     addr_a;
  logic [AW-1:0]     addr_b;
  logic              rd_en;
  logic [COEF_W-1:0] newer_q;
  logic [COEF_W-1:0] older_q;
  logic [COEF_W-1:0] nv;
  logic [COEF_W-1:0] ov;
  logic [COEF_W-1:0] next_coef;
  logic [COEF_W-1:0] emit_q;
  logic              zero_old;
  logic              we_a;
  logic              we_b;
  logic [AW-1:0]     wa_a;
  logic [AW-1:0]     wa_b;
  logic [COEF_W-1:0] wd_a;
  logic [COEF_W-1:0] wd_b;

  // Requested degree, clamped to the largest supported one.
  assign n_sat = (in_degree > MAX_DEG) ? MAX_DEG : in_degree;

  // Read addresses: the newer row at j-1 and the older row at j, or both at k.
  assign j_prev     = (j_r == '0) ? '0 : j_r - AW'(1);
  assign newer_addr = cmd.emit_rd ? k_r : j_prev;
  assign older_addr = cmd.emit_rd ? k_r : j_r;
  assign addr_a     = bank_r ? older_addr : newer_addr;
  assign addr_b     = bank_r ? newer_addr : older_addr;
  assign rd_en      = cmd.comp_step | cmd.emit_rd;

  assign newer_q = bank_r ? rd_b_r : rd_a_r;
  assign older_q = bank_r ? rd_a_r : rd_b_r;

  // Entries beyond the older row's degree, and below power zero, read as zero.
  assign zero_old = ((7'(j_r) + 7'd2) > {1'b0, i_r});

  // One recurrence element: 2 * newer[j-1] - older[j].
  assign nv        = p_zn_r ? '0 : newer_q;
  assign ov        = p_zo_r ? '0 : older_q;
  assign next_coef = {nv[COEF_W-2:0], 1'b0} - ov;

  // Degree zero is read from the older row, all others from the newer one.
  assign emit_q = (n_r == '0) ? older_q : newer_q;

  // Write port selection: seeding of T_0 and T_1, then results into the older row.
  always_comb begin
    we_a = 1'b0;
    wa_a = '0;
    wd_a = '0;
    we_b = 1'b0;
    wa_b = '0;
    wd_b = '0;
    if (cmd.init_lo) begin
      we_a = 1'b1;
      wd_a = '0;
      we_b = 1'b1;
      wd_b = COEF_ONE;
    end else if (cmd.init_hi) begin
      we_a = 1'b1;
      wa_a = AW'(1);
      wd_a = COEF_ONE;
    end else if (p_vld_r) begin
      if (bank_r) begin
        we_a = 1'b1;
        wa_a = p_j_r;
        wd_a = next_coef;
      end else begin
        we_b = 1'b1;
        wa_b = p_j_r;
        wd_b = next_coef;
      end
    end
  end

  // Memory A with registered read.
  always_ff @(posedge clk) begin
    if (we_a) mem_a[wa_a] <= wd_a;
    if (rd_en) rd_a_r <= mem_a[addr_a];
  end

  // Memory B with registered read.
  always_ff @(posedge clk) begin
    if (we_b) mem_b[wa_b] <= wd_b;
    if (rd_en) rd_b_r <= mem_b[addr_b];
  end

  // Read-to-write pipeline stage of the recurrence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= cmd.comp_step;
    end
    p_j_r  <= j_r;
    p_zn_r <= (j_r == '0);
    p_zo_r <= zero_old;
  end

  // Degree, row and element counters and the bank select.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
      bank_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        n_r    <= n_sat;
        i_r    <= DEG_W'(2);
        j_r    <= '0;
        k_r    <= '0;
        bank_r <= 1'b0;
      end
      if (cmd.comp_step) j_r <= j_r + AW'(1);
      if (cmd.row_next) begin
        i_r    <= i_r + DEG_W'(1);
        j_r    <= '0;
        bank_r <= ~bank_r;
      end
      if (cmd.emit_ld && !sts.emit_last) k_r <= k_r + AW'(1);
    end
  end

  // Output register: holds one beat until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_ld) begin
      out_coef_r  <= emit_q;
      out_power_r <= DEG_W'(k_r);
      out_last_r  <= sts.emit_last;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.n_le_one  = (n_r <= DEG_W'(1));
    sts.row_done  = (DEG_W'(j_r) == i_r);
    sts.rows_done = (i_r == n_r);
    sts.emit_last = (DEG_W'(k_r) == n_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = $signed(out_coef_r);
  assign out_power       = out_power_r;
  assign out_last        = out_last_r;

endmodule

// ===== hdl/chebyshev_coefficient_generator.sv =====
// Chebyshev polynomial (first kind) coefficient generator, top level.
//
// Input channel in_valid/in_ready carries one beat: the degree n of T_n.
// Degrees above MAX_DEGREE are clamped to MAX_DEGREE. For each request the
// block returns n+1 beats on out_valid/out_ready: the integer coefficient of
// x^power, lowest power first, with out_last set on the beat for power n.
// Two row memories hold T_(i-1) and T_i; the recurrence 2x*T_(i-1) - T_(i-2)
// runs one coefficient per cycle through a one-stage read/write pipeline,
// and each row ends with a drain step. Each beat is read from a row memory
// and then loaded into the output register. One request is worked on at a
// time; in_ready is high once the final beat is loaded into the output
// register, even while that beat still waits to be taken. A stalled receiver
// holds the output register and pauses emission. Synchronous reset clears
// the controller and empties the output register; the row memories are not
// cleared, as each request seeds them before use.
module chebyshev_coefficient_generator
  import chebcg_pkg::*;
#(
  parameter int MAX_DEGREE = 40
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DEG_W-1:0]         in_degree,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [COEF_W-1:0] out_coefficient,
  output logic [DEG_W-1:0]         out_power,
  output logic                     out_last
);

  chebcg_cmd_t cmd;
  chebcg_sts_t sts;

  // Sequencer.
  chebcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Memories, arithmetic and output register.
  chebcg_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_degree       (in_degree),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_coefficient (out_coefficient),
    .out_power       (out_power),
    .out_last        (out_last)
  );

endmodule

// ===== hdl/chebcg_checker.sv =====
// Port-level assertions for the Chebyshev coefficient generator, with bind.
`include "chebyshev_coefficient_generator_defines.svh"

module chebcg_checker
  import chebcg_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [COEF_W-1:0] out_coefficient,
  input logic [DEG_W-1:0]         out_power,
  input logic                     out_last
);

  // A stalled result beat keeps its payload.
  `CHEB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_coefficient) && $stable(out_power) && $stable(out_last))

  // No new request is taken while a run is still being emitted.
  `CHEB_ASSERT_IMP(a_busy_mid_run, clk, rst_n, out_valid && !out_last, !in_ready)

  // The leading coefficient of T_n is positive: sign bit clear and nonzero.
  `CHEB_ASSERT_IMP(a_lead_positive, clk, rst_n, out_valid && out_last, !out_coefficient[COEF_W-1] && (out_coefficient != '0))

  // Degree zero yields the constant polynomial one.
  `CHEB_ASSERT_IMP(a_deg_zero, clk, rst_n, out_valid && out_last && (out_power == '0), out_coefficient == COEF_W'(1))

endmodule

bind chebyshev_coefficient_generator chebcg_checker u_chebcg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_coefficient (out_coefficient),
  .out_power       (out_power),
  .out_last        (out_last)
);
